>>> sv/prefix_trie_store_assert.svh
`ifndef PREFIX_TRIE_STORE_ASSERT_SVH
`define PREFIX_TRIE_STORE_ASSERT_SVH

// same-cycle implication, off during reset
`define PTS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("prefix_trie_store check failed");

// next-cycle implication, off during reset
`define PTS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("prefix_trie_store check failed");

`endif

>>> sv/pts_pkg.sv
package pts_pkg;

   localparam int NODE_COUNT     = 1024;
   localparam int MAX_PREFIX_LEN = 64;
   localparam int CHAR_BITS      = 16;

   localparam int NODE_W     = $clog2(NODE_COUNT);
   localparam int HIGH_W     = NODE_W + 1;
   localparam int CNT_W      = NODE_W;
   localparam int LEN_W      = $clog2(MAX_PREFIX_LEN + 1);
   localparam int BUF_AW     = $clog2(MAX_PREFIX_LEN);
   localparam int HIST_DEPTH = MAX_PREFIX_LEN + 1;
   localparam int HIST_AW    = $clog2(HIST_DEPTH);
   localparam int CLR_CNT    = (NODE_COUNT > HIST_DEPTH) ? NODE_COUNT : HIST_DEPTH;
   localparam int CLR_W      = $clog2(CLR_CNT);
   localparam int START_W    = 6;
   localparam int OUT_LEN_W  = 7;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;
   localparam logic [1:0] OP_CLEAR  = 2'd3;

   localparam logic [3:0] ST_MATCH     = 4'd0;
   localparam logic [3:0] ST_NOMATCH   = 4'd1;
   localparam logic [3:0] ST_ADDED     = 4'd2;
   localparam logic [3:0] ST_DUPLICATE = 4'd3;
   localparam logic [3:0] ST_REMOVED   = 4'd4;
   localparam logic [3:0] ST_ABSENT    = 4'd5;
   localparam logic [3:0] ST_FULL      = 4'd6;
   localparam logic [3:0] ST_TOOLONG   = 4'd7;
   localparam logic [3:0] ST_CLEARED   = 4'd8;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [CHAR_BITS-1:0] char_code;
      logic                 last_char;
      logic [START_W-1:0]   start_offset;
   } req_type;

   typedef struct packed {
      logic [3:0]           status;
      logic [OUT_LEN_W-1:0] match_length;
      logic [OUT_LEN_W-1:0] longest_length;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0]    parent;
      logic [CHAR_BITS-1:0] symbol;
      logic [CNT_W-1:0]     count;
      logic                 accepting;
   } node_type;

endpackage

>>> sv/pts_ram.sv
module pts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

>>> sv/prefix_trie_store.sv
// A non-final character is taken while idle and buffered, with no result. A final character
// runs the command; each trie step scans nodes 1..highest through the node RAM until a hit,
// and add/remove walk the trie twice (a check walk, then an apply walk), find only once.
// Remove then scans the histogram RAM down from length 64 for the new longest length.
// Reset and clear run a pass over every node and histogram RAM entry; busy is high.
// The result shows for one cycle on rsp_valid; the receiver cannot stall.
module prefix_trie_store
   import pts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_CLR     = 5'd1;
   localparam logic [4:0] S_CHAR    = 5'd2;
   localparam logic [4:0] S_SYM     = 5'd3;
   localparam logic [4:0] S_RD      = 5'd4;
   localparam logic [4:0] S_CMP     = 5'd5;
   localparam logic [4:0] S_MISS    = 5'd6;
   localparam logic [4:0] S_WALKEND = 5'd7;
   localparam logic [4:0] S_ALLOC   = 5'd8;
   localparam logic [4:0] S_HIST    = 5'd9;
   localparam logic [4:0] S_HISTW   = 5'd10;
   localparam logic [4:0] S_LONG    = 5'd11;
   localparam logic [4:0] S_LONGW   = 5'd12;

   localparam logic [1:0] PH_WALK  = 2'd0;
   localparam logic [1:0] PH_APPLY = 2'd1;
   localparam logic [1:0] PH_FIND  = 2'd2;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PREFIX_LEN);

   logic [4:0]           state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   logic [1:0]           op_ff, op_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     start_ff, start_in;
   logic [LEN_W-1:0]     idx_ff, idx_in;
   logic [LEN_W-1:0]     pos_ff, pos_in;
   logic                 ovf_ff, ovf_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [CHAR_BITS-1:0] sym_ff, sym_in;
   logic [NODE_W-1:0]    scan_ff, scan_in;
   logic                 acc_ff, acc_in;
   logic [HIGH_W-1:0]    highest_ff, highest_in;
   logic [NODE_W-1:0]    head_ff, head_in;
   logic [NODE_W-1:0]    tail_ff, tail_in;
   logic [HIGH_W-1:0]    fcnt_ff, fcnt_in;
   logic [LEN_W-1:0]     longest_ff, longest_in;
   logic [CLR_W-1:0]     clr_ff, clr_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 buf_we;
   logic [BUF_AW-1:0]    buf_waddr;
   logic [CHAR_BITS-1:0] buf_rdata;
   logic                 node_we;
   logic [NODE_W-1:0]    node_waddr;
   node_type             node_wdata;
   node_type             node_rdata;
   logic                 fifo_we;
   logic [NODE_W-1:0]    fifo_rdata;
   logic                 hist_we;
   logic [HIST_AW-1:0]   hist_waddr;
   logic [HIST_AW-1:0]   hist_raddr;
   logic [CNT_W-1:0]     hist_wdata;
   logic [CNT_W-1:0]     hist_rdata;

   logic                 hit;
   logic                 idx_last;
   logic [LEN_W-1:0]     len_w;
   logic [HIGH_W:0]      avail;
   logic [HIGH_W:0]      need;
   logic [NODE_W-1:0]    alloc_n;

   pts_ram #(.WIDTH(CHAR_BITS), .DEPTH(MAX_PREFIX_LEN)) u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (req_data.char_code),
      .rd_addr (idx_ff[BUF_AW-1:0]),
      .rd_data (buf_rdata)
   );

   pts_ram #(.WIDTH($bits(node_type)), .DEPTH(NODE_COUNT)) u_node (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (scan_ff),
      .rd_data (node_rdata)
   );

   pts_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_fifo (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (scan_ff),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   pts_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign hist_raddr = (state_ff == S_LONG) ? idx_ff[HIST_AW-1:0] : len_ff[HIST_AW-1:0];
   assign hit = (node_rdata.count != '0) && (node_rdata.parent == node_ff) &&
                (node_rdata.symbol == sym_ff);
   assign idx_last = (idx_ff == len_ff - LEN_W'(1));
   assign avail = (HIGH_W+1)'(fcnt_ff) + (HIGH_W+1)'(NODE_COUNT - 1) - (HIGH_W+1)'(highest_ff);
   assign need  = (HIGH_W+1)'(len_ff - idx_ff);
   assign alloc_n = (fcnt_ff != '0) ? fifo_rdata : NODE_W'(highest_ff + HIGH_W'(1));
   assign len_w = (pos_ff < MAX_LEN) ? pos_ff + LEN_W'(1) : pos_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      op_in        = op_ff;
      len_in       = len_ff;
      start_in     = start_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      ovf_in       = ovf_ff;
      node_in      = node_ff;
      sym_in       = sym_ff;
      scan_in      = scan_ff;
      acc_in       = acc_ff;
      highest_in   = highest_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fcnt_in      = fcnt_ff;
      longest_in   = longest_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rsp_in.match_length = '0;
      buf_we       = 1'b0;
      buf_waddr    = pos_ff[BUF_AW-1:0];
      node_we      = 1'b0;
      node_waddr   = scan_ff;
      node_wdata   = node_rdata;
      fifo_we      = 1'b0;
      hist_we      = 1'b0;
      hist_waddr   = len_ff[HIST_AW-1:0];
      hist_wdata   = hist_rdata;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (pos_ff < MAX_LEN) begin
                  buf_we = 1'b1;
                  pos_in = pos_ff + LEN_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_char) begin
                  pos_in   = '0;
                  ovf_in   = 1'b0;
                  len_in   = len_w;
                  op_in    = req_data.opcode;
                  start_in = LEN_W'(req_data.start_offset);
                  idx_in   = '0;
                  node_in  = '0;
                  acc_in   = 1'b0;
                  phase_in = PH_WALK;
                  if (req_data.opcode == OP_CLEAR) begin
                     highest_in = '0;
                     head_in    = '0;
                     tail_in    = '0;
                     fcnt_in    = '0;
                     longest_in = '0;
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLR;
                  end else if (ovf_ff || (pos_ff >= MAX_LEN)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_TOOLONG;
                  end else if (req_data.opcode == OP_FIND) begin
                     if (LEN_W'(req_data.start_offset) >= len_w) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_NOMATCH;
                     end else begin
                        idx_in   = LEN_W'(req_data.start_offset);
                        phase_in = PH_FIND;
                        state_in = S_CHAR;
                     end
                  end else begin
                     state_in = S_CHAR;
                  end
               end
            end
         end
         S_CLR: begin
            node_we    = ({1'b0, clr_ff} < (CLR_W+1)'(NODE_COUNT));
            node_waddr = NODE_W'(clr_ff);
            node_wdata = '0;
            hist_we    = ({1'b0, clr_ff} < (CLR_W+1)'(HIST_DEPTH));
            hist_waddr = HIST_AW'(clr_ff);
            hist_wdata = '0;
            clr_in     = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_CNT - 1)) begin
               state_in      = S_IDLE;
               clr_rsp_in    = 1'b0;
               rsp_valid_in  = clr_rsp_ff;
               rsp_in.status = ST_CLEARED;
            end
         end
         S_CHAR: begin
            state_in = S_SYM;
         end
         S_SYM: begin
            sym_in  = buf_rdata;
            scan_in = NODE_W'(1);
            state_in = (highest_ff == '0) ? S_MISS : S_RD;
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (hit) begin
               node_in = scan_ff;
               idx_in  = idx_ff + LEN_W'(1);
               case (phase_ff)
                  PH_WALK: begin
                     acc_in   = node_rdata.accepting;
                     state_in = idx_last ? S_WALKEND : S_CHAR;
                  end
                  PH_APPLY: begin
                     node_we = 1'b1;
                     if (op_ff == OP_ADD) begin
                        node_wdata.count = node_rdata.count + CNT_W'(1);
                        if (idx_last) begin
                           node_wdata.accepting = 1'b1;
                        end
                     end else begin
                        if (idx_last) begin
                           node_wdata.accepting = 1'b0;
                        end
                        if (node_rdata.count <= CNT_W'(1)) begin
                           node_wdata.count = '0;
                           fifo_we = 1'b1;
                           tail_in = (tail_ff == NODE_W'(NODE_COUNT - 1)) ? '0 :
                                     tail_ff + NODE_W'(1);
                           fcnt_in = fcnt_ff + HIGH_W'(1);
                        end else begin
                           node_wdata.count = node_rdata.count - CNT_W'(1);
                        end
                     end
                     state_in = idx_last ? S_HIST : S_CHAR;
                  end
                  default: begin
                     if (node_rdata.accepting) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_MATCH;
                        rsp_in.match_length = OUT_LEN_W'(idx_ff + LEN_W'(1) - start_ff);
                        state_in = S_IDLE;
                     end else if (idx_last) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = ST_NOMATCH;
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_CHAR;
                     end
                  end
               endcase
            end else if ({1'b0, scan_ff} == highest_ff) begin
               state_in = S_MISS;
            end else begin
               scan_in  = scan_ff + NODE_W'(1);
               state_in = S_RD;
            end
         end
         S_MISS: begin
            case (phase_ff)
               PH_WALK: begin
                  state_in = S_WALKEND;
               end
               PH_APPLY: begin
                  state_in = (op_ff == OP_ADD) ? S_ALLOC : S_HIST;
               end
               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_NOMATCH;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_WALKEND: begin
            idx_in   = '0;
            node_in  = '0;
            phase_in = PH_APPLY;
            state_in = S_CHAR;
            if (op_ff == OP_ADD) begin
               if ((idx_ff == len_ff) && acc_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_DUPLICATE;
                  state_in = S_IDLE;
               end else if (need > avail) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_FULL;
                  state_in = S_IDLE;
               end
            end else if (!((idx_ff == len_ff) && acc_ff)) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_ABSENT;
               state_in = S_IDLE;
            end
         end
         S_ALLOC: begin
            if (fcnt_ff != '0) begin
               head_in = (head_ff == NODE_W'(NODE_COUNT - 1)) ? '0 : head_ff + NODE_W'(1);
               fcnt_in = fcnt_ff - HIGH_W'(1);
            end else begin
               highest_in = highest_ff + HIGH_W'(1);
            end
            node_we    = 1'b1;
            node_waddr = alloc_n;
            node_wdata.parent    = node_ff;
            node_wdata.symbol    = sym_ff;
            node_wdata.count     = CNT_W'(1);
            node_wdata.accepting = idx_last;
            node_in  = alloc_n;
            idx_in   = idx_ff + LEN_W'(1);
            state_in = idx_last ? S_HIST : S_CHAR;
         end
         S_HIST: begin
            state_in = S_HISTW;
         end
         S_HISTW: begin
            if (op_ff == OP_ADD) begin
               hist_we    = 1'b1;
               hist_wdata = hist_rdata + CNT_W'(1);
               if (len_ff > longest_ff) begin
                  longest_in = len_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_ADDED;
               state_in = S_IDLE;
            end else begin
               hist_we    = (hist_rdata != '0);
               hist_wdata = hist_rdata - CNT_W'(1);
               idx_in     = MAX_LEN;
               state_in   = S_LONG;
            end
         end
         S_LONG: begin
            state_in = S_LONGW;
         end
         S_LONGW: begin
            if ((hist_rdata != '0) || (idx_ff == LEN_W'(1))) begin
               longest_in    = (hist_rdata != '0) ? idx_ff : '0;
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_REMOVED;
               state_in = S_IDLE;
            end else begin
               idx_in   = idx_ff - LEN_W'(1);
               state_in = S_LONG;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_in.longest_length = OUT_LEN_W'(longest_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         pos_ff       <= '0;
         ovf_ff       <= 1'b0;
         highest_ff   <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fcnt_ff      <= '0;
         longest_ff   <= '0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_WALK;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         highest_ff   <= highest_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fcnt_ff      <= fcnt_in;
         longest_ff   <= longest_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
      op_ff    <= op_in;
      len_ff   <= len_in;
      start_ff <= start_in;
      idx_ff   <= idx_in;
      node_ff  <= node_in;
      sym_ff   <= sym_in;
      scan_ff  <= scan_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
   end

endmodule

>>> sv/pts_checker.sv
`include "prefix_trie_store_assert.svh"

module pts_checker
   import pts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   `PTS_ASSERT_IMP(a_rsp_when_idle, rsp_valid, !busy)
   `PTS_ASSERT_NEXT(a_no_rsp_midstring, start && !busy && !req_data.last_char, !rsp_valid && !busy)
   `PTS_ASSERT_NEXT(a_clear_goes_busy, start && !busy && req_data.last_char && (req_data.opcode == OP_CLEAR), busy)
   `PTS_ASSERT_IMP(a_match_len, rsp_valid && (rsp_data.status == ST_MATCH), rsp_data.match_length != '0)
   `PTS_ASSERT_IMP(a_nomatch_len, rsp_valid && (rsp_data.status != ST_MATCH), rsp_data.match_length == '0)

endmodule

bind prefix_trie_store pts_checker u_pts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
